FILE: hdl/cmrs_pkg.sv
// cmrs_pkg: shared types and constants of the combination record mark/scan block
// no dependencies; used by the top level, cmrs_regs, cmrs_binom and cmrs_checker
package cmrs_pkg;

  localparam int MAX_SET_SIZE = 8;
  localparam int ELEMENT_BITS = 8;
  localparam int BINOM_W      = 50;
  localparam int BINOM_ROWS   = 256;
  localparam int COUNT_W      = 17;

  typedef logic [MAX_SET_SIZE:0][BINOM_W-1:0] binom_row_t;

  typedef struct packed {
    logic [3:0]  set_size;
    logic [7:0]  lowest_top_value;
    logic [7:0]  highest_value;
    logic [7:0]  scan_mask;
    logic [7:0]  scan_pattern;
    logic [15:0] scan_offset;
    logic [16:0] scan_stride;
  } cfg_t;

  localparam logic [1:0] CMD_MARK    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_FETCH   = 2'd2;

  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_ALREADY   = 3'd1;
  localparam logic [2:0] ST_REJECT    = 3'd2;
  localparam logic [2:0] ST_MATCH     = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;
  localparam logic [2:0] ST_RESTARTED = 3'd5;

  localparam logic [2:0] REG_SET_SIZE     = 3'd0;
  localparam logic [2:0] REG_LOWEST_TOP   = 3'd1;
  localparam logic [2:0] REG_HIGHEST      = 3'd2;
  localparam logic [2:0] REG_SCAN_MASK    = 3'd3;
  localparam logic [2:0] REG_SCAN_PATTERN = 3'd4;
  localparam logic [2:0] REG_SCAN_OFFSET  = 3'd5;
  localparam logic [2:0] REG_SCAN_STRIDE  = 3'd6;

endpackage

FILE: hdl/cmrs_if.sv
// cmrs_in_if / cmrs_out_if: request and result channels with valid/ready
// no dependencies
interface cmrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] set_packed;
  logic [7:0]  mark_bits;
  modport source(output valid, command, set_packed, mark_bits, input ready);
  modport sink(input valid, command, set_packed, mark_bits, output ready);
endinterface

interface cmrs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] found_set;
  logic [16:0] match_count;
  modport source(output valid, status, found_set, match_count, input ready);
  modport sink(input valid, status, found_set, match_count, output ready);
endinterface

FILE: hdl/combination_record_mark_scan.sv
// combination_record_mark_scan: k-subset record store with mark and scan
// depends on cmrs_pkg, cmrs_if, cmrs_regs, cmrs_binom, cmrs_store
//
// requests enter on in_ch (valid/ready), one result per request leaves on out_ch.
// configuration is written through the apb port while the block is idle.
// the user is bound to that; the block does not enforce it. after reset
// the block clears its record memory and builds its binomial table, one
// entry a cycle: in_ch.ready stays low until both are done. one request
// is worked at a time by a sequencer around one binomial memory read port
// and the record memory's read and write ports; the steps per request:
//   mark:    one binomial lookup per set element, then a record update
//   restart: the cursor is set to scan_offset and the match count cleared
//   fetch:   entries are examined until one matches or the scan ends, and
//            a match rebuilds the matching set element by element, each
//            by bit-wise search
// the next request is taken the cycle after a result is loaded.
// a finished result waits in the output register while out_ch.ready is low;
// a new request is taken meanwhile, and its result waits for the register.
module combination_record_mark_scan #(
  parameter int RECORD_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst,
  cmrs_in_if.sink            in_ch,
  cmrs_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW     = $clog2(RECORD_DEPTH);
  localparam int CUR_W  = $clog2(RECORD_DEPTH + 1);
  localparam int CW     = (CUR_W > 16) ? CUR_W : 16;
  localparam int SUM_W  = ((CW > 17) ? CW : 17) + 1;
  localparam int BW     = cmrs_pkg::BINOM_W;
  localparam logic [CW-1:0]    DEPTH_C  = CW'(RECORD_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(RECORD_DEPTH);
  localparam logic [BW-1:0]    DEPTH_B  = BW'(RECORD_DEPTH);
  localparam logic [16:0]      COUNT_MX = 17'h1FFFF;

  typedef enum logic [3:0] {
    IDLE, G_BASE, G_HI, G_TOT, M_ELEM, M_ACC, M_IDX, M_RD,
    F_CHECK, F_TEST, U_BIT, U_CMP, U_EMIT, FIN
  } state_t;

  cmrs_pkg::cfg_t       cfg;
  cmrs_pkg::binom_row_t bin_row;
  logic                 bin_done;
  logic [7:0]           bin_raddr;
  logic                 st_ready;
  logic                 st_we;
  logic [AW-1:0]        st_raddr;
  logic [7:0]           st_rdata;

  state_t        state;
  logic [1:0]    cmd;
  logic [63:0]   set_r;
  logic [7:0]    bits_r;
  logic [2:0]    j;
  logic [BW-1:0] rank;
  logic [BW-1:0] base;
  logic [CW-1:0] tot;
  logic [CW-1:0] cursor;
  logic [AW-1:0] idx;
  logic [BW-1:0] rem;
  logic [BW-1:0] cval;
  logic [7:0]    ui;
  logic [2:0]    ub;
  logic [3:0]    v;
  logic [63:0]   found;
  logic [2:0]    status_r;
  logic [16:0]   match_cnt;
  logic          out_valid;
  logic [2:0]    out_status;
  logic [63:0]   out_found;
  logic [16:0]   out_count;

  logic [3:0]       k;
  logic [7:0]       lo;
  logic [7:0]       hi;
  logic [2:0]       km1;
  logic [7:0]       e_cur;
  logic [7:0]       e_prev;
  logic [7:0]       e_top;
  logic [BW-1:0]    diff;
  logic [BW-1:0]    tsub;
  logic [SUM_W-1:0] sum;
  logic [16:0]      stride;
  logic [7:0]       cand;
  logic             hit;

  cmrs_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  cmrs_binom u_binom (
    .clk, .rst, .rd_addr(bin_raddr), .rd_row(bin_row), .done(bin_done)
  );

  cmrs_store #(.DEPTH(RECORD_DEPTH)) u_store (
    .clk, .rst, .wr_en(st_we), .wr_addr(idx), .wr_data(st_rdata | bits_r),
    .rd_addr(st_raddr), .rd_data(st_rdata), .ready(st_ready)
  );

  always_comb begin
    if (cfg.set_size == 4'd0) begin
      k = 4'd1;
    end else if (cfg.set_size > 4'(cmrs_pkg::MAX_SET_SIZE)) begin
      k = 4'(cmrs_pkg::MAX_SET_SIZE);
    end else begin
      k = cfg.set_size;
    end
    lo     = (cfg.lowest_top_value < {4'd0, k}) ? {4'd0, k} : cfg.lowest_top_value;
    hi     = cfg.highest_value;
    km1    = 3'(k - 4'd1);
    e_cur  = set_r[{j, 3'b000} +: 8];
    e_prev = set_r[{3'(j - 3'd1), 3'b000} +: 8];
    e_top  = set_r[{km1, 3'b000} +: 8];
    diff   = rank - base;
    tsub   = bin_row[k] - base;
    stride = (cfg.scan_stride == 17'd0) ? 17'd1 : cfg.scan_stride;
    sum    = SUM_W'(cursor) + SUM_W'(stride);
    cand   = ui | (8'd1 << ub);
    if (cfg.scan_mask != 8'd0) begin
      hit = (st_rdata & cfg.scan_mask) == (cfg.scan_pattern & cfg.scan_mask);
    end else begin
      hit = ((st_rdata & cfg.scan_pattern) != 8'd0) || (cfg.scan_pattern == 8'd0);
    end
  end

  always_comb begin
    case (state)
      G_BASE:  bin_raddr = lo - 8'd1;
      G_HI:    bin_raddr = hi;
      M_ELEM:  bin_raddr = e_cur - 8'd1;
      U_BIT:   bin_raddr = cand;
      default: bin_raddr = 8'd0;
    endcase
    case (state)
      M_IDX:   st_raddr = diff[AW-1:0];
      F_CHECK: st_raddr = cursor[AW-1:0];
      default: st_raddr = '0;
    endcase
    st_we = (state == M_RD);
  end

  assign in_ch.ready        = (state == IDLE) && bin_done && st_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.found_set   = out_found;
  assign out_ch.match_count = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      match_cnt <= 17'd0;
      cursor    <= '0;
    end else begin
      if (out_valid && out_ch.ready && state != FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cmd    <= in_ch.command;
            set_r  <= in_ch.set_packed;
            bits_r <= in_ch.mark_bits;
            found  <= 64'd0;
            if (in_ch.command == cmrs_pkg::CMD_MARK || in_ch.command == cmrs_pkg::CMD_RESTART
                || in_ch.command == cmrs_pkg::CMD_FETCH) begin
              state <= G_BASE;
            end else begin
              status_r <= cmrs_pkg::ST_REJECT;
              state    <= FIN;
            end
          end
        end
        G_BASE: state <= G_HI;
        G_HI: begin
          base  <= bin_row[k];
          state <= G_TOT;
        end
        G_TOT: begin
          if (hi < lo) begin
            tot <= '0;
          end else if (tsub > DEPTH_B) begin
            tot <= DEPTH_C;
          end else begin
            tot <= CW'(tsub);
          end
          case (cmd)
            cmrs_pkg::CMD_MARK: begin
              j     <= 3'd0;
              rank  <= '0;
              state <= M_ELEM;
            end
            cmrs_pkg::CMD_RESTART: begin
              cursor    <= CW'(cfg.scan_offset);
              match_cnt <= 17'd0;
              status_r  <= cmrs_pkg::ST_RESTARTED;
              state     <= FIN;
            end
            default: state <= F_CHECK;
          endcase
        end
        M_ELEM: begin
          if (e_cur == 8'd0 || e_cur > hi || (j != 3'd0 && e_cur <= e_prev)) begin
            status_r <= cmrs_pkg::ST_REJECT;
            state    <= FIN;
          end else begin
            state <= M_ACC;
          end
        end
        M_ACC: begin
          rank <= rank + bin_row[4'(j) + 4'd1];
          if (j == km1) begin
            state <= M_IDX;
          end else begin
            j     <= j + 3'd1;
            state <= M_ELEM;
          end
        end
        M_IDX: begin
          idx <= diff[AW-1:0];
          if (e_top < lo || diff >= DEPTH_B) begin
            status_r <= cmrs_pkg::ST_REJECT;
            state    <= FIN;
          end else begin
            state <= M_RD;
          end
        end
        M_RD: begin
          status_r <= ((st_rdata & bits_r) != bits_r) ? cmrs_pkg::ST_NEW
                                                      : cmrs_pkg::ST_ALREADY;
          state    <= FIN;
        end
        F_CHECK: begin
          if (cursor < tot) begin
            idx    <= cursor[AW-1:0];
            cursor <= (sum > DEPTH_S) ? DEPTH_C : CW'(sum);
            state  <= F_TEST;
          end else begin
            status_r <= cmrs_pkg::ST_DONE;
            state    <= FIN;
          end
        end
        F_TEST: begin
          if (hit) begin
            if (match_cnt != COUNT_MX) begin
              match_cnt <= match_cnt + 17'd1;
            end
            rem   <= base + BW'(idx);
            v     <= k;
            ui    <= 8'd0;
            ub    <= 3'd7;
            cval  <= '0;
            state <= U_BIT;
          end else begin
            state <= F_CHECK;
          end
        end
        U_BIT: state <= U_CMP;
        U_CMP: begin
          if (bin_row[v] <= rem) begin
            ui   <= cand;
            cval <= bin_row[v];
          end
          if (ub == 3'd0) begin
            state <= U_EMIT;
          end else begin
            ub    <= ub - 3'd1;
            state <= U_BIT;
          end
        end
        U_EMIT: begin
          rem <= rem - cval;
          found[{3'(v - 4'd1), 3'b000} +: 8] <= ui + 8'd1;
          if (v == 4'd1) begin
            status_r <= cmrs_pkg::ST_MATCH;
            state    <= FIN;
          end else begin
            v     <= v - 4'd1;
            ui    <= 8'd0;
            ub    <= 3'd7;
            cval  <= '0;
            state <= U_BIT;
          end
        end
        FIN: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_status <= status_r;
            out_found  <= found;
            out_count  <= match_cnt;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/cmrs_regs.sv
// cmrs_regs: apb configuration registers
// depends on cmrs_pkg
module cmrs_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cmrs_pkg::cfg_t      cfg
);

  logic [2:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_size         <= 4'd4;
      cfg.lowest_top_value <= 8'd4;
      cfg.highest_value    <= 8'd32;
      cfg.scan_mask        <= 8'd0;
      cfg.scan_pattern     <= 8'd0;
      cfg.scan_offset      <= 16'd0;
      cfg.scan_stride      <= 17'd1;
    end else if (wr_en) begin
      case (reg_sel)
        cmrs_pkg::REG_SET_SIZE:     cfg.set_size         <= pwdata[3:0];
        cmrs_pkg::REG_LOWEST_TOP:   cfg.lowest_top_value <= pwdata[7:0];
        cmrs_pkg::REG_HIGHEST:      cfg.highest_value    <= pwdata[7:0];
        cmrs_pkg::REG_SCAN_MASK:    cfg.scan_mask        <= pwdata[7:0];
        cmrs_pkg::REG_SCAN_PATTERN: cfg.scan_pattern     <= pwdata[7:0];
        cmrs_pkg::REG_SCAN_OFFSET:  cfg.scan_offset      <= pwdata[15:0];
        cmrs_pkg::REG_SCAN_STRIDE:  cfg.scan_stride      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      cmrs_pkg::REG_SET_SIZE:     prdata = {28'd0, cfg.set_size};
      cmrs_pkg::REG_LOWEST_TOP:   prdata = {24'd0, cfg.lowest_top_value};
      cmrs_pkg::REG_HIGHEST:      prdata = {24'd0, cfg.highest_value};
      cmrs_pkg::REG_SCAN_MASK:    prdata = {24'd0, cfg.scan_mask};
      cmrs_pkg::REG_SCAN_PATTERN: prdata = {24'd0, cfg.scan_pattern};
      cmrs_pkg::REG_SCAN_OFFSET:  prdata = {16'd0, cfg.scan_offset};
      cmrs_pkg::REG_SCAN_STRIDE:  prdata = {15'd0, cfg.scan_stride};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

FILE: hdl/cmrs_binom.sv
// cmrs_binom: binomial coefficient memory, one row C(m,0..8) per m
// filled by a pascal sweep after reset; depends on cmrs_pkg
module cmrs_binom (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           rd_addr,
  output cmrs_pkg::binom_row_t rd_row,
  output logic                 done
);

  cmrs_pkg::binom_row_t mem [cmrs_pkg::BINOM_ROWS];
  cmrs_pkg::binom_row_t prev_row;
  cmrs_pkg::binom_row_t row_next;
  logic [7:0]           fill_cnt;

  always_comb begin
    row_next    = '0;
    row_next[0] = cmrs_pkg::BINOM_W'(1);
    if (fill_cnt != 8'd0) begin
      for (int n = 1; n <= cmrs_pkg::MAX_SET_SIZE; n++) begin
        row_next[n] = prev_row[n] + prev_row[n-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= 8'd0;
      done     <= 1'b0;
    end else if (!done) begin
      if (fill_cnt == 8'hFF) begin
        done <= 1'b1;
      end else begin
        fill_cnt <= fill_cnt + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!done) begin
      mem[fill_cnt] <= row_next;
      prev_row      <= row_next;
    end
    rd_row <= mem[rd_addr];
  end

endmodule

FILE: hdl/cmrs_store.sv
// cmrs_store: byte-wide record memory with a clearing pass after reset
// depends on nothing but its parameter
module cmrs_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output logic          ready
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_cnt;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  always_comb begin
    we    = ready ? wr_en : 1'b1;
    waddr = ready ? wr_addr : clr_cnt;
    wdata = ready ? wr_data : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      ready   <= 1'b0;
    end else if (!ready) begin
      if (clr_cnt == AW'(DEPTH - 1)) begin
        ready <= 1'b1;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/cmrs_checker.sv
// cmrs_checker: port-level checks of combination_record_mark_scan, bound to the top
// depends on cmrs_pkg and the top level's ports
module cmrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [63:0] found_set
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= cmrs_pkg::ST_RESTARTED)
    else $error("bad status code");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cmrs_pkg::ST_MATCH |-> found_set == 64'd0)
    else $error("set shown without a match");

endmodule

bind combination_record_mark_scan cmrs_checker u_cmrs_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .found_set(out_ch.found_set)
);
